/* hdl/line_pattern_last_match_assert.svh */
// assertion macros for the line pattern search block
// expects signals named clock and reset in the including module
`ifndef LINE_PATTERN_LAST_MATCH_ASSERT_SVH
`define LINE_PATTERN_LAST_MATCH_ASSERT_SVH

// property checked at every edge outside reset
`define LPLM_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define LPLM_CHECK_NEXT(label, trig, prop, msg) \
   `LPLM_CHECK(label, (trig) |=> (prop), msg)

`endif

/* hdl/lplm_pkg.sv */
// constants and field widths for the line pattern search block
// no dependencies
`default_nettype none

package lplm_pkg;

   localparam int MAX_LINE    = 1024;
   localparam int MAX_PATTERN = 8;

   localparam int CHAR_W    = 8;
   localparam int POS_W     = 10;
   localparam int START_W   = POS_W + 1;
   localparam int COUNT_W   = 16;
   localparam int PLEN_W    = 4;
   localparam int WINDOW_W  = CHAR_W * MAX_PATTERN;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 64;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELD_W = START_W + POS_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 1'd1;

   localparam logic [CHAR_W-1:0] CH_AT = 8'h40;
   localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;

   localparam logic [WINDOW_W-1:0] PATTERN_RESET = 64'h0000_0000_646C_756F;
   localparam logic [PLEN_W-1:0]   PLEN_RESET    = 4'd4;
   localparam logic [PLEN_W-1:0]   PLEN_MAX      = PLEN_W'(MAX_PATTERN);

   localparam logic [POS_W-1:0]   LINE_FULL  = POS_W'(MAX_LINE - 1);
   localparam logic [START_W-1:0] START_NONE = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

endpackage

`default_nettype wire

/* hdl/line_pattern_last_match.sv */
// line pattern search: splits a byte stream into lines and reports the last match
// depends on lplm_pkg and line_pattern_last_match_assert.svh
//
// usage
//   req channel: one character per transfer, tdata[7:0] char_byte, tuser end_of_input
//   rsp channel: one result per completed line or at stream close
//   csr port: csr_we with csr_index 0 (pattern bytes) or 1 (pattern length)
// result timing: a result is on rsp in the cycle after the transfer that closes the line
// throughput: one character per cycle while req_tready is high; the window compare and the line state update
//   sit between the input handshake and the single result register
// stall: the result register holds while rsp_tready is low; req_tready stays high
//   as long as that register is empty or being emptied in the same cycle
// reset: synchronous; clears line state, match count and the done flag and loads
//   the default pattern "ould" of length 4
// after a close (end_of_input, or '@' on an empty line) characters are still
//   taken but produce no result until reset
`default_nettype none

module line_pattern_last_match (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [lplm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lplm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [lplm_pkg::REQ_DATA_W-1:0]    req_tdata,  // char_byte
   input  wire logic                               req_tuser,  // end_of_input
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // match_start[10:0], line_length[20:11], matched_lines[36:21], zero fill
   output      logic [lplm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic                               rsp_tuser,  // line_valid
   output      logic                               rsp_tlast   // stream_done
);
   import lplm_pkg::*;

   logic [WINDOW_W-1:0] pattern_ff, pattern_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic [WINDOW_W-1:0] recent_ff, recent_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                finished_ff, finished_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0]  out_start_ff, out_start_in;
   logic [POS_W-1:0]    out_len_ff, out_len_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic                out_line_ff, out_line_in;
   logic                out_done_ff, out_done_in;
   logic                out_load;

   logic                take;
   logic [CHAR_W-1:0]   char_byte;
   logic                eoi;
   logic [PLEN_W-1:0]   used_len;
   logic [WINDOW_W-1:0] shifted;
   logic [POS_W-1:0]    pos_next;
   logic [MAX_PATTERN:0] hit;
   logic                match_now;
   logic [START_W-1:0]  start_stored;

   assign char_byte = req_tdata[CHAR_W-1:0];
   assign eoi       = req_tuser;
   assign take      = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   assign used_len = (plen_ff > PLEN_MAX) ? PLEN_MAX : plen_ff;
   assign shifted  = {char_byte, recent_ff[WINDOW_W-1:CHAR_W]};
   assign pos_next = pos_ff + 1'b1;

   // window compare for every pattern length
   assign hit[0] = 1'b0;
   for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cmp
      assign hit[k] = shifted[WINDOW_W-1 -: CHAR_W*k] == pattern_ff[CHAR_W*k-1:0];
   end

   assign match_now = (used_len != '0) && (pos_next >= POS_W'(used_len)) && hit[used_len];
   assign start_stored = match_now ? ({1'b0, pos_next} - START_W'(used_len)) : start_ff;

   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:  pattern_in = csr_wdata;
            CSR_PATTERN_LENGTH: plen_in    = csr_wdata[PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      recent_in    = recent_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      out_load     = 1'b0;
      out_start_in = out_start_ff;
      out_len_in   = out_len_ff;
      out_count_in = out_count_ff;
      out_line_in  = out_line_ff;
      out_done_in  = out_done_ff;
      if (take && !finished_ff) begin
         if (eoi || char_byte == CH_AT) begin
            out_load    = 1'b1;
            out_done_in = eoi;
            if (pos_ff == '0) begin
               finished_in  = 1'b1;
               out_done_in  = 1'b1;
               out_line_in  = 1'b0;
               out_start_in = START_NONE;
               out_len_in   = '0;
               out_count_in = count_ff;
            end else begin
               finished_in = eoi;
               if (!start_ff[START_W-1] && count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               out_line_in  = 1'b1;
               out_start_in = start_ff;
               out_len_in   = pos_ff;
               out_count_in = count_in;
               recent_in    = '0;
               pos_in       = '0;
               start_in     = START_NONE;
            end
         end else begin
            recent_in = shifted;
            pos_in    = pos_next;
            start_in  = start_stored;
            if (char_byte == CH_NL || pos_next >= LINE_FULL) begin
               if (!start_stored[START_W-1] && count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               out_load     = 1'b1;
               out_done_in  = 1'b0;
               out_line_in  = 1'b1;
               out_start_in = start_stored;
               out_len_in   = pos_next;
               out_count_in = count_in;
               recent_in    = '0;
               pos_in       = '0;
               start_in     = START_NONE;
            end
         end
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= PATTERN_RESET;
         plen_ff      <= PLEN_RESET;
         recent_ff    <= '0;
         pos_ff       <= '0;
         start_ff     <= START_NONE;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         plen_ff      <= plen_in;
         recent_ff    <= recent_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_start_ff <= out_start_in;
      out_len_ff   <= out_len_in;
      out_count_ff <= out_count_in;
      out_line_ff  <= out_line_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_count_ff, out_len_ff, out_start_ff});
   assign rsp_tuser  = out_line_ff;
   assign rsp_tlast  = out_done_ff;

`include "line_pattern_last_match_assert.svh"

   `LPLM_CHECK(a_close_only_result, (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && out_start_ff == START_NONE && out_len_ff == '0), "result without a line must close the stream")
   `LPLM_CHECK(a_start_in_line, (rsp_tvalid && rsp_tuser && !out_start_ff[START_W-1]) |-> (out_start_ff < {1'b0, out_len_ff}), "match start beyond line length")
   `LPLM_CHECK_NEXT(a_done_frozen, finished_ff, (finished_ff && $stable(count_ff) && pos_ff == '0), "state changed after stream close")

endmodule

`default_nettype wire
